>>> sv/pressure_temperature_compensation_assert.svh
// Assertion macros for the pressure and temperature compensation block.
`ifndef PRESSURE_TEMPERATURE_COMPENSATION_ASSERT_SVH
`define PRESSURE_TEMPERATURE_COMPENSATION_ASSERT_SVH
`ifndef SYNTHESIS
// Check a consequence in the same cycle as its antecedent.
`define PTC_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("ptc assertion failed");
// Check a consequence in the cycle after its antecedent.
`define PTC_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("ptc assertion failed");
`else
`define PTC_ASSERT_NOW(label, clk, rst, ante, cons)
`define PTC_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

>>> sv/ptc_pkg.sv
// Shared types, constants and arithmetic helpers for the compensation pipeline.
package ptc_pkg;

   localparam int RAW_W       = 20;
   localparam int OUT_W       = 32;
   localparam int CSR_W       = 64;
   localparam int DIV_BITS    = 64;
   localparam int REM_W       = 31;
   localparam int ST_DZ       = 8;
   localparam int ST_DIV0     = 9;
   localparam int ST_Q        = ST_DIV0 + DIV_BITS;
   localparam int NUM_STAGES  = ST_Q + 5;
   localparam int FINE_OFFSET = 128000;
   localparam int PRESS_BASE  = 1048576;
   localparam int PRESS_SCALE = 3125;
   localparam int ROUND_HALF  = 128;

   typedef enum logic [1:0] {
      CSR_TEMP       = 2'd0,
      CSR_PRESS_LOW  = 2'd1,
      CSR_PRESS_HIGH = 2'd2,
      CSR_PRESS_NINE = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic signed [OUT_W-1:0] temperature_centi;
      logic signed [OUT_W-1:0] fine_temperature;
      logic                    divisor_zero;
   } meta_type;

   typedef struct packed {
      logic signed [OUT_W-1:0] temperature_centi;
      logic signed [OUT_W-1:0] fine_temperature;
      logic [OUT_W-1:0]        pressure_q24_8;
      logic                    divisor_zero;
   } result_type;

   // Low 64 bits of a 64-bit word times a signed 16-bit word.
   function automatic logic [63:0] mul64x16s(input logic [63:0] a,
                                            input logic signed [15:0] b);
      logic [63:0] pu;
      logic [63:0] corr;
      pu   = a * {48'd0, b};
      corr = b[15] ? {a[47:0], 16'd0} : 64'd0;
      return pu - corr;
   endfunction

endpackage

>>> sv/ptc_req_if.sv
// Input channel carrying one raw temperature and pressure pair.
interface ptc_req_if;
   logic                       valid;
   logic                       ready;
   logic [ptc_pkg::RAW_W-1:0]  raw_temperature;
   logic [ptc_pkg::RAW_W-1:0]  raw_pressure;

   modport source (output valid, output raw_temperature, output raw_pressure, input ready);
   modport sink   (input valid, input raw_temperature, input raw_pressure, output ready);
endinterface

>>> sv/ptc_rsp_if.sv
// Result channel carrying compensated temperature and pressure.
interface ptc_rsp_if;
   logic                              valid;
   logic                              ready;
   logic signed [ptc_pkg::OUT_W-1:0]  temperature_centi;
   logic signed [ptc_pkg::OUT_W-1:0]  fine_temperature;
   logic [ptc_pkg::OUT_W-1:0]         pressure_q24_8;
   logic                              divisor_zero;

   modport source (output valid, output temperature_centi, output fine_temperature,
                   output pressure_q24_8, output divisor_zero, input ready);
   modport sink   (input valid, input temperature_centi, input fine_temperature,
                   input pressure_q24_8, input divisor_zero, output ready);
endinterface

>>> sv/pressure_temperature_compensation.sv
// Top level: pipelined barometer temperature and pressure compensation.
// Throughput: one pair per cycle while the skid entry is empty; the 64-stage restoring
//    divider (one quotient bit per stage) sets the depth, with multipliers and adders spread
//    over the stages around it.
// A two-entry output buffer (output register plus skid entry) lets the pipeline keep going
//    for one more transfer while a result waits.
// Reset (synchronous, active high) clears all valid bits and the calibration registers to zero.
`include "pressure_temperature_compensation_assert.svh"

module pressure_temperature_compensation (
   input  logic                        clock,
   input  logic                        reset,
   ptc_req_if.sink                     req,
   ptc_rsp_if.source                   rsp,
   input  logic                        csr_we,
   input  ptc_pkg::csr_index_type      csr_index,
   input  logic [ptc_pkg::CSR_W-1:0]   csr_wdata
);

   localparam int NS = ptc_pkg::NUM_STAGES;
   localparam int DB = ptc_pkg::DIV_BITS;
   localparam int RW = ptc_pkg::REM_W;
   localparam int D0 = ptc_pkg::ST_DIV0;
   localparam int SQ = ptc_pkg::ST_Q;

   // ---------------------------------------------------------------- calibration
   logic [47:0] temp_cal_ff;
   logic [63:0] press_low_ff;
   logic [63:0] press_high_ff;
   logic [15:0] press_nine_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         temp_cal_ff   <= '0;
         press_low_ff  <= '0;
         press_high_ff <= '0;
         press_nine_ff <= '0;
      end else if (csr_we) begin
         unique case (csr_index)
            ptc_pkg::CSR_TEMP:       temp_cal_ff   <= csr_wdata[47:0];
            ptc_pkg::CSR_PRESS_LOW:  press_low_ff  <= csr_wdata;
            ptc_pkg::CSR_PRESS_HIGH: press_high_ff <= csr_wdata;
            ptc_pkg::CSR_PRESS_NINE: press_nine_ff <= csr_wdata[15:0];
            default:                 press_nine_ff <= press_nine_ff;
         endcase
      end
   end

   // Calibration words; the user must change configuration only while the pipeline is empty (not enforced here).
   logic [15:0]        t1, p1;
   logic signed [15:0] t2, t3, p2, p3, p4, p5, p6, p7, p8, p9;
   assign t1 = temp_cal_ff[15:0];
   assign t2 = temp_cal_ff[31:16];
   assign t3 = temp_cal_ff[47:32];
   assign p1 = press_low_ff[15:0];
   assign p2 = press_low_ff[31:16];
   assign p3 = press_low_ff[47:32];
   assign p4 = press_low_ff[63:48];
   assign p5 = press_high_ff[15:0];
   assign p6 = press_high_ff[31:16];
   assign p7 = press_high_ff[47:32];
   assign p8 = press_high_ff[63:48];
   assign p9 = press_nine_ff;

   // ---------------------------------------------------------------- flow control
   // The whole pipeline advances together; it only holds when the skid entry is full.
   logic          advance;
   logic [NS-1:0] v_ff;
   logic          main_v_ff, skid_v_ff;

   assign advance   = !skid_v_ff;
   assign req.ready = advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (advance) begin
         v_ff <= {v_ff[NS-2:0], req.valid};
      end
   end

   // ---------------------------------------------------------------- temperature
   logic signed [18:0] ta_in;
   logic signed [34:0] tv1_in, tv1_ff;
   logic signed [17:0] td_in;
   logic signed [35:0] dd_in, dd_ff;
   logic [20:0]        pd_in;
   logic [20:0]        pd_ff [0:5];

   always_comb begin
      ta_in  = $signed({2'b00, req.raw_temperature[19:3]}) - $signed({2'b00, t1, 1'b0});
      tv1_in = (ta_in * t2) >>> 11;
      td_in  = $signed({2'b00, req.raw_temperature[19:4]}) - $signed({2'b00, t1});
      dd_in  = td_in * td_in;
      pd_in  = 21'(ptc_pkg::PRESS_BASE) - {1'b0, req.raw_pressure};
   end

   logic signed [39:0]          tp_in, tsum_in;
   logic signed [31:0]          tfine_in, tfine_ff;

   always_comb begin
      tp_in    = $signed(dd_ff[35:12]) * t3;
      tsum_in  = 40'(tv1_ff) + (tp_in >>> 14);
      tfine_in = tsum_in[31:0];
   end

   logic signed [39:0] tc_in;
   logic signed [32:0] v1_in, v1_ff;
   ptc_pkg::meta_type  meta_in;
   ptc_pkg::meta_type  meta_ff [2:NS-2];

   always_comb begin
      tc_in = (40'(tfine_ff) * 40'sd5 + 40'(ptc_pkg::ROUND_HALF)) >>> 8;
      v1_in = 33'(tfine_ff) - 33'(ptc_pkg::FINE_OFFSET);
      meta_in.temperature_centi = tc_in[31:0];
      meta_in.fine_temperature  = tfine_ff;
      meta_in.divisor_zero      = 1'b0;
   end

   // ---------------------------------------------------------------- pressure, before divide
   logic signed [65:0] vsq_in;
   logic signed [48:0] vp5_in, vp2_in, vp5_ff, vp2_ff, vp5d_ff, vp2d_ff;
   logic [63:0]        vv_ff, a6_ff, a3_ff;
   logic [63:0]        v2_in, v2_ff, s6_in, s6_ff;
   logic [63:0]        prod_ff, num0_ff, num_ff;
   logic [30:0]        divr_ff;

   always_comb begin
      vsq_in = v1_ff * v1_ff;
      vp5_in = v1_ff * p5;
      vp2_in = v1_ff * p2;
      v2_in  = a6_ff + (64'(vp5d_ff) << 17) + (64'(p4) << 35);
      s6_in  = 64'h0000_8000_0000_0000 + 64'($signed(a3_ff) >>> 8) + (64'(vp2d_ff) << 12);
   end

   // Divider setup: magnitudes and quotient sign.
   logic [DB-1:0] work_ff [D0-1:SQ-1];
   logic [RW-1:0] rem_ff  [D0-1:SQ-1];
   logic [RW-1:0] ad_ff   [D0-1:SQ-1];
   logic          qneg_ff [D0-1:SQ-1];

   // ---------------------------------------------------------------- pipeline payload
   always_ff @(posedge clock) begin
      if (advance) begin
         tv1_ff   <= tv1_in;
         dd_ff    <= dd_in;
         pd_ff[0] <= pd_in;
         for (int i = 1; i < 6; i++) begin
            pd_ff[i] <= pd_ff[i-1];
         end
         tfine_ff   <= tfine_in;
         meta_ff[2] <= meta_in;
         v1_ff      <= v1_in;
         vv_ff      <= vsq_in[63:0];
         vp5_ff     <= vp5_in;
         vp2_ff     <= vp2_in;
         a6_ff      <= ptc_pkg::mul64x16s(vv_ff, p6);
         a3_ff      <= ptc_pkg::mul64x16s(vv_ff, p3);
         vp5d_ff    <= vp5_ff;
         vp2d_ff    <= vp2_ff;
         v2_ff      <= v2_in;
         s6_ff      <= s6_in;
         prod_ff    <= s6_ff * {48'd0, p1};
         num0_ff    <= (64'(pd_ff[5]) << 31) - v2_ff;
         divr_ff    <= prod_ff[63:33];
         num_ff     <= num0_ff * 64'(ptc_pkg::PRESS_SCALE);
         // stage 8: split signs off for the unsigned divider
         work_ff[D0-1] <= num_ff[63] ? (64'd0 - num_ff) : num_ff;
         ad_ff[D0-1]   <= divr_ff[30] ? (31'd0 - divr_ff) : divr_ff;
         qneg_ff[D0-1] <= num_ff[63] ^ divr_ff[30];
         rem_ff[D0-1]  <= '0;
         for (int i = 3; i < NS - 1; i++) begin
            if (i == ptc_pkg::ST_DZ) begin
               // flag a zero divisor as the item leaves the divisor stage
               meta_ff[i] <= {meta_ff[i-1].temperature_centi, meta_ff[i-1].fine_temperature,
                              divr_ff == '0};
            end else begin
               meta_ff[i] <= meta_ff[i-1];
            end
         end
      end
   end

   // ---------------------------------------------------------------- divider
   // One restoring step per stage: shift in a dividend bit, subtract when it fits.
   for (genvar j = 0; j < DB; j++) begin : g_div
      localparam int S = D0 + j;
      logic [RW:0]   rsh_in;
      logic          ge_in;
      logic [RW:0]   rdiff_in;

      always_comb begin
         rsh_in   = {rem_ff[S-1], work_ff[S-1][DB-1]};
         ge_in    = rsh_in >= {1'b0, ad_ff[S-1]};
         rdiff_in = ge_in ? (rsh_in - {1'b0, ad_ff[S-1]}) : rsh_in;
      end

      always_ff @(posedge clock) begin
         if (advance) begin
            rem_ff[S]  <= rdiff_in[RW-1:0];
            work_ff[S] <= {work_ff[S-1][DB-2:0], ge_in};
            ad_ff[S]   <= ad_ff[S-1];
            qneg_ff[S] <= qneg_ff[S-1];
         end
      end
   end

   // ---------------------------------------------------------------- pressure, after divide
   logic [63:0]        qa_ff, qb_ff, qc_ff, qd_ff;
   logic signed [63:0] ps_in;
   logic [63:0]        xl2_ff, sq_ff;
   logic [31:0]        cross_in, cross_ff;
   logic [63:0]        w2_in, w2b_ff, w2c_ff, w2d_ff, w1_ff;
   logic [63:0]        psum_in, pres_in;
   ptc_pkg::result_type res_in, res_ff;

   always_comb begin
      ps_in    = $signed(qa_ff) >>> 13;
      cross_in = ps_in[63:32] * ps_in[31:0];
      w2_in    = 64'($signed(ptc_pkg::mul64x16s(qa_ff, p8)) >>> 19);
      psum_in  = qd_ff + w1_ff + w2d_ff;
      pres_in  = 64'($signed(psum_in) >>> 8) + (64'(p7) << 4);
      res_in.temperature_centi = meta_ff[NS-2].temperature_centi;
      res_in.fine_temperature  = meta_ff[NS-2].fine_temperature;
      res_in.divisor_zero      = meta_ff[NS-2].divisor_zero;
      res_in.pressure_q24_8    = meta_ff[NS-2].divisor_zero ? '0 : pres_in[31:0];
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         qa_ff    <= qneg_ff[SQ-1] ? (64'd0 - work_ff[SQ-1]) : work_ff[SQ-1];
         qb_ff    <= qa_ff;
         xl2_ff   <= ps_in[31:0] * ps_in[31:0];
         cross_ff <= cross_in;
         w2b_ff   <= w2_in;
         // square of a 64-bit word modulo 2^64 from its halves
         qc_ff    <= qb_ff;
         sq_ff    <= xl2_ff + {cross_ff[30:0], 33'd0};
         w2c_ff   <= w2b_ff;
         qd_ff    <= qc_ff;
         w1_ff    <= 64'($signed(ptc_pkg::mul64x16s(sq_ff, p9)) >>> 25);
         w2d_ff   <= w2c_ff;
         res_ff   <= res_in;
      end
   end

   // ---------------------------------------------------------------- output buffer
   ptc_pkg::result_type main_ff, skid_ff;
   logic                leave;

   assign leave = v_ff[NS-1] && advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         main_v_ff <= 1'b0;
         skid_v_ff <= 1'b0;
      end else begin
         if (!main_v_ff || rsp.ready) begin
            // refill from the skid entry first, else take the item leaving the pipeline
            main_v_ff <= skid_v_ff || leave;
            skid_v_ff <= 1'b0;
         end else if (leave) begin
            skid_v_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (!main_v_ff || rsp.ready) begin
         main_ff <= skid_v_ff ? skid_ff : res_ff;
      end else if (leave) begin
         skid_ff <= res_ff;
      end
   end

   assign rsp.valid             = main_v_ff;
   assign rsp.temperature_centi = main_ff.temperature_centi;
   assign rsp.fine_temperature  = main_ff.fine_temperature;
   assign rsp.pressure_q24_8    = main_ff.pressure_q24_8;
   assign rsp.divisor_zero      = main_ff.divisor_zero;

   // ---------------------------------------------------------------- assertions
   `PTC_ASSERT_NOW(a_dz_clears_pressure, clock, reset, rsp.valid && rsp.divisor_zero, rsp.pressure_q24_8 == '0)
   `PTC_ASSERT_NOW(a_skid_needs_main, clock, reset, skid_v_ff, main_v_ff)
   `PTC_ASSERT_NEXT(a_transfer_enters, clock, reset, req.valid && req.ready, v_ff[0])
   `PTC_ASSERT_NOW(a_rem_below_divisor, clock, reset, v_ff[SQ-1] && !meta_ff[SQ-1].divisor_zero, rem_ff[SQ-1] < ad_ff[SQ-1])

endmodule
